/* hdl/oqsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqsm_pkg: shared constants for the OFDM QAM subcarrier mapper
// Mode codes, constellation levels in signed Q2.14 and level lookup helpers.
// ----------------------------------------------------------------------------
package oqsm_pkg;

    // field widths
    localparam int BITS_W  = 6;
    localparam int LEVEL_W = 16;
    localparam int BIN_W   = 6;
    localparam int SYM_W   = 16;

    // modulation_mode codes (code 3 falls back to 64QAM)
    localparam logic [1:0] MODE_QPSK  = 2'd0;
    localparam logic [1:0] MODE_16QAM = 2'd1;
    localparam logic [1:0] MODE_64QAM = 2'd2;

    // scaled levels, Q2.14
    localparam logic signed [LEVEL_W-1:0] LV_QPSK  = 16'sd11585;
    localparam logic signed [LEVEL_W-1:0] LV_16_1  = 16'sd5181;
    localparam logic signed [LEVEL_W-1:0] LV_16_3  = 16'sd15543;
    localparam logic signed [LEVEL_W-1:0] LV_64_1  = 16'sd2528;
    localparam logic signed [LEVEL_W-1:0] LV_64_3  = 16'sd7584;
    localparam logic signed [LEVEL_W-1:0] LV_64_5  = 16'sd12641;
    localparam logic signed [LEVEL_W-1:0] LV_64_7  = 16'sd17697;

    // 16QAM level; first bit of the pair is the MSB of idx
    function automatic logic signed [LEVEL_W-1:0] f_lv16(input logic [1:0] idx);
        logic signed [LEVEL_W-1:0] v;
        case (idx)
            2'd0:    v = -LV_16_3;
            2'd1:    v = -LV_16_1;
            2'd2:    v = LV_16_3;
            default: v = LV_16_1;
        endcase
        return v;
    endfunction

    // 64QAM level; Gray-coded magnitude, MSB is the sign
    function automatic logic signed [LEVEL_W-1:0] f_lv64(input logic [2:0] idx);
        logic signed [LEVEL_W-1:0] mag;
        case (idx[1:0])
            2'd0:    mag = LV_64_7;
            2'd1:    mag = LV_64_5;
            2'd2:    mag = LV_64_1;
            default: mag = LV_64_3;
        endcase
        return idx[2] ? mag : -mag;
    endfunction

endpackage

/* hdl/ofdm_qam_subcarrier_mapper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_qam_subcarrier_mapper_top: OFDM QAM mapper with IFFT bin placement
// Maps coded bit groups to QPSK/16QAM/64QAM points and orders them by bin.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per subcarrier: code_bits in tdata[5:0].
//   m_axis carries I/Q points with bin and symbol number; tlast marks the
//   final value of each OFDM symbol.
//   APB registers: 0x0 modulation_mode, 0x4 output_order. Write them only
//   while the block is idle.
// Timing:
//   An item is taken in S_IDLE and its point is loaded into the output
//   register in S_EMIT once the output register is free; s_axis_tready is
//   low until then, so no new item is taken before the last one loads. In bin
//   order the lower half of the subcarriers is written to the holding memory
//   and produces nothing; the last subcarrier then adds FFT_SIZE-USED_CARRIERS
//   zero-fill items and, per held entry, a memory read and then a map and
//   load, during which s_axis_tready stays low.
// Reset: synchronous, clears position, symbol count, registers and output.
// Backpressure: a stalled output holds its value; the block waits with the
//   next result until the output register is free.
// ----------------------------------------------------------------------------
module ofdm_qam_subcarrier_mapper_top #(
    parameter int USED_CARRIERS = 48,
    parameter int FFT_SIZE      = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] code_bits, [7:6] zero
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] in_phase, [31:16] quadrature,
                                        // [37:32] bin_number,
                                        // [53:38] symbol_number, [55:54] zero
    output logic        m_axis_tlast,   // last_of_symbol
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import oqsm_pkg::*;

    localparam int HALF     = USED_CARRIERS / 2;
    localparam int AW       = (HALF > 1) ? $clog2(HALF) : 1;
    localparam bit HAS_FILL = FFT_SIZE > USED_CARRIERS;

    localparam logic [BIN_W-1:0] LAST_POS   = BIN_W'(USED_CARRIERS - 1);
    localparam logic [BIN_W-1:0] HALF_POS   = BIN_W'(HALF);
    localparam logic [BIN_W-1:0] BIN_TOP    = BIN_W'(FFT_SIZE - 1);
    localparam logic [BIN_W-1:0] FILL_FIRST = BIN_W'(USED_CARRIERS - HALF);
    localparam logic [BIN_W-1:0] FILL_END   =
        HAS_FILL ? BIN_W'(FFT_SIZE - HALF - 1) : '0;
    localparam logic [BIN_W-1:0] HELD_FIRST =
        BIN_W'((FFT_SIZE - (HALF % FFT_SIZE)) % FFT_SIZE);
    localparam logic [AW-1:0]    HELD_LAST  = AW'(HALF - 1);

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_ORDER     = 1'b1;
    localparam logic ORDER_NATURAL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_FILL,
        S_HREAD,
        S_HOUT
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_mode;
    logic                       r_order;
    logic [BIN_W-1:0]           r_pos;
    logic [SYM_W-1:0]           r_sym;
    logic [BIN_W-1:0]           r_upbin;
    logic [BITS_W-1:0]          r_bits;
    logic [BIN_W-1:0]           r_cur_pos;
    logic [BIN_W-1:0]           r_cur_bin;
    logic                       r_cur_last;
    logic [BIN_W-1:0]           r_fbin;
    logic [AW-1:0]              r_hidx;
    logic [BIN_W-1:0]           r_hbin;
    logic                       r_ovalid;
    logic signed [LEVEL_W-1:0]  r_oi;
    logic signed [LEVEL_W-1:0]  r_oq;
    logic [BIN_W-1:0]           r_obin;
    logic [SYM_W-1:0]           r_osym;
    logic                       r_olast;

    logic                       w_in_acc;
    logic                       w_is_last;
    logic                       w_slot;
    logic                       w_load;
    logic                       w_natural;
    logic                       w_cfg_wr;
    logic [BITS_W-1:0]          w_rdata;
    logic [BITS_W-1:0]          w_map_bits;
    logic signed [LEVEL_W-1:0]  w_map_i;
    logic signed [LEVEL_W-1:0]  w_map_q;

    function automatic logic [BIN_W-1:0] f_bin_inc(input logic [BIN_W-1:0] b);
        return (b == BIN_TOP) ? '0 : b + BIN_W'(1);
    endfunction

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_is_last     = r_pos >= LAST_POS;
    assign w_slot        = !r_ovalid || m_axis_tready;
    assign w_natural     = (r_order == ORDER_NATURAL);
    assign w_cfg_wr      = psel && penable && pwrite && pready;

    // output register takes a new item this cycle
    assign w_load = w_slot &&
                    ((r_state == S_EMIT && (w_natural || (r_cur_pos >= HALF_POS))) ||
                     (r_state == S_FILL) || (r_state == S_HOUT));

    // config readback
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_MODE: prdata = {30'd0, r_mode};
            default:  prdata = {31'd0, r_order};
        endcase
    end

    // holding store: written on every lower-half arrival, read while draining
    oqsm_hold_mem #(
        .DEPTH (HALF),
        .AW    (AW)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (r_pos < HALF_POS)),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (s_axis_tdata[BITS_W-1:0]),
        .i_re    (r_state == S_HREAD),
        .i_raddr (r_hidx),
        .o_rdata (w_rdata)
    );

    // one mapper shared by direct and held items
    assign w_map_bits = (r_state == S_HOUT) ? w_rdata : r_bits;

    oqsm_mapper u_map (
        .i_bits       (w_map_bits),
        .i_mode       (r_mode),
        .o_in_phase   (w_map_i),
        .o_quadrature (w_map_q)
    );

    // sequencer, position tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_QPSK;
            r_order  <= 1'b0;
            r_pos    <= '0;
            r_sym    <= '0;
            r_upbin  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_MODE: r_mode  <= pwdata[1:0];
                    default:  r_order <= pwdata[0];
                endcase
            end

            // drained item leaves the output register unless a new one loads
            if (m_axis_tready && !w_load) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_bits     <= s_axis_tdata[BITS_W-1:0];
                        r_cur_pos  <= r_pos;
                        r_cur_bin  <= r_upbin;
                        r_cur_last <= w_is_last;
                        if (w_is_last) begin
                            r_pos   <= '0;
                            r_upbin <= '0;
                        end else begin
                            r_pos <= r_pos + BIN_W'(1);
                            if (r_pos >= HALF_POS) begin
                                r_upbin <= f_bin_inc(r_upbin);
                            end
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_natural || (r_cur_pos >= HALF_POS)) begin
                        if (w_slot) begin
                            r_ovalid <= 1'b1;
                            r_oi     <= w_map_i;
                            r_oq     <= w_map_q;
                            r_obin   <= w_natural ? r_cur_pos : r_cur_bin;
                            r_osym   <= r_sym;
                            r_olast  <= w_natural && r_cur_last;
                            if (r_cur_last && w_natural) begin
                                r_sym   <= r_sym + SYM_W'(1);
                                r_state <= S_IDLE;
                            end else if (r_cur_last) begin
                                r_fbin  <= FILL_FIRST;
                                r_hidx  <= '0;
                                r_hbin  <= HELD_FIRST;
                                r_state <= HAS_FILL ? S_FILL : S_HREAD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        // lower half in bin order: held only
                        r_state <= S_IDLE;
                    end
                end
                S_FILL: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_oi     <= '0;
                        r_oq     <= '0;
                        r_obin   <= r_fbin;
                        r_osym   <= r_sym;
                        r_olast  <= 1'b0;
                        r_fbin   <= r_fbin + BIN_W'(1);
                        if (r_fbin == FILL_END) begin
                            r_state <= S_HREAD;
                        end
                    end
                end
                S_HREAD: begin
                    r_state <= S_HOUT;
                end
                S_HOUT: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_oi     <= w_map_i;
                        r_oq     <= w_map_q;
                        r_obin   <= r_hbin;
                        r_osym   <= r_sym;
                        r_olast  <= (r_hidx == HELD_LAST);
                        if (r_hidx == HELD_LAST) begin
                            r_sym   <= r_sym + SYM_W'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_hidx  <= r_hidx + AW'(1);
                            r_hbin  <= f_bin_inc(r_hbin);
                            r_state <= S_HREAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output ports
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_osym, r_obin, r_oq, r_oi};
    assign m_axis_tlast  = r_olast;

    // the held drain ends a symbol, so the position must already be rewound
    a_pos_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOUT && w_slot && r_hidx == HELD_LAST) |=> (r_pos == '0))
        else $error("position not rewound at end of held drain");

    // the final value of a symbol sits in the top bin or the last subcarrier
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            ((w_natural && r_obin == LAST_POS) || (!w_natural && r_obin == BIN_TOP)))
        else $error("end of symbol in unexpected bin");

    // symbol count moves only as a symbol completes
    a_sym_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_sym)) |->
            (r_state == S_IDLE && r_pos == '0))
        else $error("symbol count advanced mid-symbol");

endmodule

/* hdl/oqsm_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqsm_mapper: constellation mapper
// Turns one subcarrier's bit group into an I/Q point for the current mode.
// ----------------------------------------------------------------------------
module oqsm_mapper (
    input  logic [oqsm_pkg::BITS_W-1:0]         i_bits,
    input  logic [1:0]                          i_mode,
    output logic signed [oqsm_pkg::LEVEL_W-1:0] o_in_phase,
    output logic signed [oqsm_pkg::LEVEL_W-1:0] o_quadrature
);
    import oqsm_pkg::*;

    // bit 0 is first in the stream and becomes the MSB of the I index
    always_comb begin
        unique case (i_mode)
            MODE_QPSK: begin
                o_in_phase   = i_bits[0] ? LV_QPSK : -LV_QPSK;
                o_quadrature = i_bits[1] ? LV_QPSK : -LV_QPSK;
            end
            MODE_16QAM: begin
                o_in_phase   = f_lv16({i_bits[0], i_bits[1]});
                o_quadrature = f_lv16({i_bits[2], i_bits[3]});
            end
            default: begin
                // 64QAM, also taken by the spare mode code
                o_in_phase   = f_lv64({i_bits[0], i_bits[1], i_bits[2]});
                o_quadrature = f_lv64({i_bits[3], i_bits[4], i_bits[5]});
            end
        endcase
    end

endmodule

/* hdl/oqsm_hold_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqsm_hold_mem: lower-half holding store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oqsm_hold_mem #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [oqsm_pkg::BITS_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [oqsm_pkg::BITS_W-1:0] o_rdata
);
    import oqsm_pkg::*;

    logic [BITS_W-1:0] r_mem [DEPTH];
    logic [BITS_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/ofdm_qam_subcarrier_mapper_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_qam_subcarrier_mapper_top_tb: self-checking bench for the QAM mapper
// Feeds coded bit groups on the input stream, predicts every I/Q point, zero
// fill and held lower-half readout, and checks each result item in order.
// Registers are rewritten between phases while the block is quiet; both
// stream sides idle at random, with one phase of steady flow.
// ----------------------------------------------------------------------------
module ofdm_qam_subcarrier_mapper_top_tb;
    import oqsm_pkg::*;

    localparam int USED_CARRIERS = 48;
    localparam int FFT_SIZE      = 64;
    localparam int HALF_CARRIERS = USED_CARRIERS / 2;
    localparam int ITEM_TARGET   = 380;
    localparam int QUIET_CYCLES  = 12;
    localparam int IDLE_PERCENT  = 23;

    // mode code 3 is undefined in the package and decodes as 64QAM
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam logic       ORDER_BIN     = 1'b0;
    localparam logic       ORDER_NATURAL = 1'b1;
    localparam logic [2:0] ADDR_MODE     = 3'h0;
    localparam logic [2:0] ADDR_ORDER    = 3'h4;

    typedef struct {
        logic signed [15:0] in_phase;
        logic signed [15:0] quadrature;
        logic [5:0]         bin_number;
        logic [15:0]        symbol_number;
        logic               last_of_symbol;
    } t_iq_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [5:0] code_bits, [7:6] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // [15:0] in_phase, [31:16] quadrature,
                                      // [37:32] bin_number, [53:38] symbol_number
    logic        m_axis_tlast;        // last_of_symbol
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // mapper mirror state
    logic [5:0]  held_bits [HALF_CARRIERS];
    int          carrier_pos = 0;
    logic [15:0] symbol_count = '0;
    logic [1:0]  cfg_mode = MODE_QPSK;
    logic        cfg_order = ORDER_BIN;

    logic [5:0]  pending_bits [$];
    t_iq_point   expected_points [$];
    int          items_issued = 0;
    int          items_taken = 0;
    int          mismatches = 0;
    bit          steady_flow = 1'b0;

    ofdm_qam_subcarrier_mapper_top #(
        .USED_CARRIERS(USED_CARRIERS),
        .FFT_SIZE     (FFT_SIZE)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // bits per axis for the current mode
    function automatic int axis_bits(input logic [1:0] mode);
        if (mode == MODE_QPSK) begin
            return 1;
        end else if (mode == MODE_16QAM) begin
            return 2;
        end
        return 3;
    endfunction

    // level for the group starting at bit 'first'; earlier bit is more significant
    function automatic logic signed [15:0] axis_level(input logic [5:0] bits,
                                                      input int first,
                                                      input logic [1:0] mode);
        logic [2:0]         grp;
        logic signed [15:0] mag;
        grp = {bits[first], bits[first+1], bits[first+2]};
        if (mode == MODE_QPSK) begin
            return grp[2] ? LV_QPSK : -LV_QPSK;
        end else if (mode == MODE_16QAM) begin
            case (grp[2:1])
                2'b00:   return -LV_16_3;
                2'b01:   return -LV_16_1;
                2'b10:   return LV_16_3;
                default: return LV_16_1;
            endcase
        end
        case (grp[1:0])
            2'b00:   mag = LV_64_7;
            2'b01:   mag = LV_64_5;
            2'b10:   mag = LV_64_1;
            default: mag = LV_64_3;
        endcase
        return grp[2] ? mag : -mag;
    endfunction

    function automatic void push_point(input logic [5:0] bits, input bit zero,
                                       input int bin, input bit last);
        t_iq_point p;
        p.in_phase       = zero ? 16'sd0 : axis_level(bits, 0, cfg_mode);
        p.quadrature     = zero ? 16'sd0 : axis_level(bits, axis_bits(cfg_mode), cfg_mode);
        p.bin_number     = bin[5:0];
        p.symbol_number  = symbol_count;
        p.last_of_symbol = last;
        expected_points.push_back(p);
    endfunction

    // predict the results caused by one subcarrier item
    function automatic void map_subcarrier(input logic [5:0] bits);
        int pos;
        bit last;
        pos  = carrier_pos;
        last = (pos >= USED_CARRIERS - 1);
        if (pos < HALF_CARRIERS) begin
            held_bits[pos] = bits;
        end
        if (cfg_order == ORDER_NATURAL) begin
            push_point(bits, 1'b0, pos, last);
        end else begin
            if (pos >= HALF_CARRIERS) begin
                push_point(bits, 1'b0, (pos - HALF_CARRIERS) % FFT_SIZE, 1'b0);
            end
            if (last) begin
                // middle bins carry zeros, then the held lower half wraps to the top
                for (int b = USED_CARRIERS - HALF_CARRIERS; b < FFT_SIZE - HALF_CARRIERS; b++) begin
                    push_point('0, 1'b1, b, 1'b0);
                end
                for (int j = 0; j < HALF_CARRIERS; j++) begin
                    push_point(held_bits[j], 1'b0, (j + FFT_SIZE - HALF_CARRIERS) % FFT_SIZE,
                               j == HALF_CARRIERS - 1);
                end
            end
        end
        if (last) begin
            carrier_pos  = 0;
            symbol_count = symbol_count + 16'd1;
        end else begin
            carrier_pos = pos + 1;
        end
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // input driver: takes items from the pending queue, predicts on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                map_subcarrier(s_axis_tdata[5:0]);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bits.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, pending_bits.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls
    always @(posedge i_clk) begin
        t_iq_point want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_points.size() == 0) begin
                    report($sformatf("unexpected item, tdata %h tlast %b",
                                     m_axis_tdata, m_axis_tlast));
                end else begin
                    want = expected_points.pop_front();
                    if (m_axis_tdata[15:0] !== want.in_phase ||
                        m_axis_tdata[31:16] !== want.quadrature ||
                        m_axis_tdata[37:32] !== want.bin_number ||
                        m_axis_tdata[53:38] !== want.symbol_number ||
                        m_axis_tlast !== want.last_of_symbol) begin
                        report($sformatf({"sym %0d bin %0d: got I %h Q %h bin %0d sym %0d",
                                          " last %b, want I %h Q %h bin %0d sym %0d last %b"},
                                         want.symbol_number, want.bin_number,
                                         m_axis_tdata[15:0], m_axis_tdata[31:16],
                                         m_axis_tdata[37:32], m_axis_tdata[53:38],
                                         m_axis_tlast, want.in_phase, want.quadrature,
                                         want.bin_number, want.symbol_number,
                                         want.last_of_symbol));
                    end
                end
            end
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [1:0] mode, input logic order);
        apb_write(ADDR_MODE, {30'd0, mode});
        cfg_mode = mode;
        apb_write(ADDR_ORDER, {31'd0, order});
        cfg_order = order;
    endtask

    // wait until every queued item is taken and every result has arrived
    task automatic wait_quiet();
        @(negedge i_clk);
        while (items_taken != items_issued || expected_points.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_item(input logic [5:0] bits);
        pending_bits.push_back(bits);
        items_issued++;
    endtask

    initial begin
        int          phase;
        int          count;
        logic [1:0]  mode;
        logic        order;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fixed points for each mode, every QPSK point, in natural order
        set_config(MODE_QPSK, ORDER_NATURAL);
        for (int k = 0; k < 4; k++) begin
            queue_item(k[5:0]);
        end
        wait_quiet();
        set_config(MODE_16QAM, ORDER_NATURAL);
        queue_item(6'h00);
        queue_item(6'h0f);
        queue_item(6'h05);
        queue_item(6'h0a);
        queue_item(6'h3c);   // upper bits must be ignored
        wait_quiet();
        set_config(MODE_64QAM, ORDER_NATURAL);
        queue_item(6'h00);
        queue_item(6'h3f);
        queue_item(6'h07);
        queue_item(6'h38);
        queue_item(6'h15);
        queue_item(6'h2a);
        wait_quiet();
        set_config(MODE_SPARE, ORDER_NATURAL);
        queue_item(6'h1b);
        queue_item(6'h24);
        wait_quiet();

        // random phases; order and mode change mid-symbol at phase borders
        phase = 0;
        while (items_issued < ITEM_TARGET) begin
            mode  = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
            order = (phase == 1 || $urandom_range(0, 3) == 0) ? ORDER_NATURAL : ORDER_BIN;
            steady_flow = (phase == 2);
            set_config(mode, order);
            count = $urandom_range(20, 110);
            if (count > ITEM_TARGET - items_issued) begin
                count = ITEM_TARGET - items_issued;
            end
            repeat (count) queue_item(6'($urandom_range(0, 63)));
            wait_quiet();
            phase++;
        end
        steady_flow = 1'b0;

        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            report($sformatf("%0d results never arrived", expected_points.size()));
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
